// ===== sv/nalsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nalsp_pkg
// Types and constants shared by the Annex-B NAL splitter modules.
// ----------------------------------------------------------------------------
package nalsp_pkg;

  localparam int unsigned ZeroRunMaxDef = 255;
  localparam int unsigned RunCountMax   = 255;

  localparam logic [7:0] StartCodeByte = 8'h01;
  localparam logic [7:0] MinStartZeros = 8'd2;
  localparam logic [7:0] NalTypeMask   = 8'h1F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       packet_last;
  } nalsp_in_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] zeros_before;
    logic       zeros_clipped;
    logic       first_of_nal;
    logic [4:0] nal_type;
    logic       end_of_nal;
  } nalsp_out_t;

endpackage : nalsp_pkg
`default_nettype wire

// ===== sv/nalsp_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nalsp_in_stage
// Input register: holds one accepted item until the parser takes it.
// ----------------------------------------------------------------------------
module nalsp_in_stage
  import nalsp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire nalsp_in_t in_item_i,
  input  wire logic      take_i,
  output logic           item_vld_o,
  output nalsp_in_t      item_o
);

  logic      vld_q, vld_d;
  nalsp_in_t item_q;

  assign in_stall_o = vld_q && !take_i;
  assign vld_d      = in_stall_o ? vld_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule : nalsp_in_stage
`default_nettype wire

// ===== sv/nalsp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nalsp_core
// Start code detection, zero run count and unit tracking for one byte.
// ----------------------------------------------------------------------------
module nalsp_core
  import nalsp_pkg::*;
#(
  parameter int unsigned ZERO_RUN_MAX = ZeroRunMaxDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      advance_i,
  input  wire nalsp_in_t item_i,
  output logic           emit_o,
  output nalsp_out_t     res_o
);

  localparam logic [7:0] RunCap = (ZERO_RUN_MAX > RunCountMax) ? 8'(RunCountMax)
                                                               : 8'(ZERO_RUN_MAX);

  logic       inside_q, inside_d;
  logic [7:0] zero_run_q, zero_run_d;
  logic       clip_q, clip_d;
  logic       has_data_q, has_data_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q   <= 1'b0;
      zero_run_q <= '0;
      clip_q     <= 1'b0;
      has_data_q <= 1'b0;
    end else if (advance_i) begin
      inside_q   <= inside_d;
      zero_run_q <= zero_run_d;
      clip_q     <= clip_d;
      has_data_q <= has_data_d;
    end
  end

  always_comb begin
    inside_d   = inside_q;
    zero_run_d = zero_run_q;
    clip_d     = clip_q;
    has_data_d = has_data_q;
    emit_o     = 1'b0;
    res_o      = '0;

    if (item_i.in_byte == '0) begin
      if (zero_run_q < RunCap) begin
        zero_run_d = zero_run_q + 8'd1;
      end else begin
        clip_d = 1'b1;
      end
    end else if (item_i.in_byte == StartCodeByte && zero_run_q >= MinStartZeros) begin
      if (inside_q && has_data_q) begin
        emit_o           = 1'b1;
        res_o.end_of_nal = 1'b1;
      end
      inside_d   = 1'b1;
      has_data_d = 1'b0;
      zero_run_d = '0;
      clip_d     = 1'b0;
    end else if (inside_q) begin
      emit_o              = 1'b1;
      res_o.data_valid    = 1'b1;
      res_o.data_byte     = item_i.in_byte;
      res_o.zeros_before  = zero_run_q;
      res_o.zeros_clipped = clip_q;
      if (!has_data_q) begin
        res_o.first_of_nal = 1'b1;
        res_o.nal_type     = (zero_run_q != '0) ? 5'd0
                                                : 5'(item_i.in_byte & NalTypeMask);
      end
      has_data_d = 1'b1;
      zero_run_d = '0;
      clip_d     = 1'b0;
    end else begin
      zero_run_d = '0;
      clip_d     = 1'b0;
    end

    if (item_i.packet_last) begin
      if (inside_d && has_data_d && !res_o.end_of_nal) begin
        emit_o           = 1'b1;
        res_o.end_of_nal = 1'b1;
      end
      inside_d   = 1'b0;
      zero_run_d = '0;
      clip_d     = 1'b0;
      has_data_d = 1'b0;
    end
  end

endmodule : nalsp_core
`default_nettype wire

// ===== sv/annex_b_nal_splitter.sv =====
// Path: an accepted byte waits in the input register; its result is registered
//   in the result register once the output is free and shown from then on.
// Throughput: one byte per cycle unless the output stalls; the input and the
//   result registers part the sides; one more byte fits while a result waits.
// Reset: asynchronous, clears the valid flags and the parser state (outside
//   any unit, no pending zeros); no clearing pass, ready at once.
`default_nettype none
// ----------------------------------------------------------------------------
// annex_b_nal_splitter
// Cuts an Annex-B byte stream into NAL units, one byte per item.
// ----------------------------------------------------------------------------
module annex_b_nal_splitter
  import nalsp_pkg::*;
#(
  parameter int unsigned ZERO_RUN_MAX = ZeroRunMaxDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire nalsp_in_t  in_item_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output nalsp_out_t      out_item_o
);

  logic       item_vld;
  nalsp_in_t  item;
  logic       out_ready;
  logic       advance;
  logic       emit;
  nalsp_out_t res;
  logic       out_vld_q, out_vld_d;
  nalsp_out_t out_item_q;

  assign out_ready = !out_vld_q || !out_stall_i;
  assign advance   = item_vld && out_ready;

  nalsp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .take_i     (advance),
    .item_vld_o (item_vld),
    .item_o     (item)
  );

  nalsp_core #(
    .ZERO_RUN_MAX (ZERO_RUN_MAX)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .emit_o    (emit),
    .res_o     (res)
  );

  assign out_vld_d = out_ready ? (advance && emit) : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && advance && emit) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule : annex_b_nal_splitter
`default_nettype wire

// ===== sv/nalsp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nalsp_checker
// Port-level checks on the NAL splitter's result items.
// ----------------------------------------------------------------------------
module nalsp_checker
  import nalsp_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire nalsp_out_t out_item_o
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  // a pure close carries only end_of_nal
  a_pure_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.data_valid |->
      out_item_o.end_of_nal && out_item_o.data_byte == '0 &&
      out_item_o.zeros_before == '0 && !out_item_o.zeros_clipped &&
      !out_item_o.first_of_nal && out_item_o.nal_type == '0)
    else $error("close item with stray fields");

  // data bytes are never zero
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.data_valid |-> out_item_o.data_byte != '0)
    else $error("zero data byte given out");

  // type only on the first item of a unit
  a_type_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.first_of_nal |-> out_item_o.nal_type == '0)
    else $error("nal_type outside first item");

  // no result can appear without an item having been accepted earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i, 2) && !$past(in_stall_o, 2))
    else $error("result item without an accepted byte");

endmodule : nalsp_checker

bind annex_b_nal_splitter nalsp_checker u_nalsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire
